### sv/pbv_pkg.sv
// shared types and constants of the packed bit vector
package pbv_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int CAPACITY_MAX = 4096;
  localparam int POS_W        = $clog2(CAPACITY_MAX + 1);
  localparam int BYTE_BITS    = 8;
  localparam int S_TDATA_W    = 24;
  localparam int S_TUSER_W    = 3;
  localparam int M_TDATA_W    = 16;
  localparam int M_TUSER_W    = 2;
  localparam int COUNT_OUT_W  = 9;

  typedef enum logic [2:0] {
    OP_APPEND_BIT  = 3'd0,
    OP_APPEND_BYTE = 3'd1,
    OP_INSERT_BIT  = 3'd2,
    OP_INSERT_BYTE = 3'd3,
    OP_ERASE       = 3'd4,
    OP_READ        = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                 write;
    logic                 erase;
    logic                 wide;
    logic [POS_W-1:0]     pos;
    logic                 bit_value;
    logic [BYTE_BITS-1:0] byte_value;
  } cell_ctrl_t;

endpackage

### sv/pbv_dec.sv
// request decode: range checks, new bit count and the cell command
module pbv_dec #(
  parameter int CAPACITY = pbv_pkg::CAPACITY_DEF,
  parameter int CntW     = $clog2(CAPACITY + 1)
) (
  input  logic                  go_i,
  input  pbv_pkg::op_e          op_i,
  input  logic [7:0]            index_i,
  input  logic                  bit_value_i,
  input  logic [7:0]            byte_value_i,
  input  logic [CntW-1:0]       cnt_i,
  output pbv_pkg::cell_ctrl_t   ctrl_o,
  output pbv_pkg::status_e      status_o,
  output logic                  rd_ok_o,
  output logic [CntW-1:0]       cnt_d_o
);
  import pbv_pkg::*;

  logic [POS_W-1:0] cnt_w;
  logic [POS_W-1:0] idx_w;
  logic [POS_W-1:0] add_n;
  logic             is_add;
  logic             wide;

  always_comb begin
    cnt_w             = POS_W'(cnt_i);
    idx_w             = POS_W'(index_i);
    is_add            = 1'b0;
    wide              = 1'b0;
    add_n             = POS_W'(1);
    ctrl_o            = '0;
    ctrl_o.pos        = idx_w;
    ctrl_o.bit_value  = bit_value_i;
    ctrl_o.byte_value = byte_value_i;
    status_o          = ST_OK;
    rd_ok_o           = 1'b0;
    cnt_d_o           = cnt_i;
    case (op_i)
      OP_APPEND_BIT: begin
        is_add     = 1'b1;
        ctrl_o.pos = cnt_w;
      end
      OP_APPEND_BYTE: begin
        is_add     = 1'b1;
        wide       = 1'b1;
        ctrl_o.pos = cnt_w;
      end
      OP_INSERT_BIT: begin
        is_add = 1'b1;
      end
      OP_INSERT_BYTE: begin
        is_add = 1'b1;
        wide   = 1'b1;
      end
      OP_ERASE: begin
        if (idx_w >= cnt_w) begin
          status_o = ST_BAD_INDEX;
        end else begin
          ctrl_o.erase = go_i;
          cnt_d_o      = cnt_i - CntW'(1);
        end
      end
      OP_READ: begin
        if (idx_w >= cnt_w) begin
          status_o = ST_BAD_INDEX;
        end else begin
          rd_ok_o = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (is_add) begin
      add_n = wide ? POS_W'(BYTE_BITS) : POS_W'(1);
      // index is checked before capacity
      if (ctrl_o.pos > cnt_w) begin
        status_o = ST_BAD_INDEX;
      end else if (cnt_w + add_n > POS_W'(CAPACITY)) begin
        status_o = ST_FULL;
      end else begin
        ctrl_o.write = go_i;
        cnt_d_o      = CntW'(cnt_w + add_n);
      end
    end
    ctrl_o.wide = wide;
  end

endmodule

### sv/pbv_cell.sv
// one bit cell of the row, shifting up or down from its neighbors
module pbv_cell #(
  parameter int IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbv_pkg::cell_ctrl_t ctrl_i,
  input  logic                lower_i,
  input  logic                lower8_i,
  input  logic                upper_i,
  output logic                bit_o
);
  import pbv_pkg::*;

  localparam logic [POS_W-1:0] MyPos = POS_W'(IDX);

  logic             bit_q;
  logic             bit_d;
  logic [POS_W-1:0] offset;
  logic             at_or_above;

  always_comb begin
    at_or_above = MyPos >= ctrl_i.pos;
    offset      = MyPos - ctrl_i.pos;
    bit_d       = bit_q;
    if (ctrl_i.write && at_or_above) begin
      if (ctrl_i.wide) begin
        if (offset < POS_W'(BYTE_BITS)) begin
          // msb of the byte lands at pos
          bit_d = ctrl_i.byte_value[~offset[2:0]];
        end else begin
          bit_d = lower8_i;
        end
      end else begin
        bit_d = (offset == '0) ? ctrl_i.bit_value : lower_i;
      end
    end else if (ctrl_i.erase && at_or_above) begin
      bit_d = upper_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

### sv/packed_bit_vector.sv
// top level of the packed bit vector with insert and erase
//
// usage:
//   requests come in on the s_ channel: tuser carries the operation code,
//   tdata carries index, bit value and byte value. each request yields one
//   result on the m_ channel: tdata carries the read bit and the bit count
//   after the request, tuser carries the status (ok, full, bad index).
//   the vector lives in a row of CAPACITY one-bit cells; every cell compares
//   its own position with the request position and, in the same cycle,
//   takes its neighbor one below (insert bit), eight below (insert byte) or
//   one above (erase), so an insert or erase of any length updates the whole row at once.
//   result: registered, it shows up on the cycle after the request is taken.
//   throughput: one request per cycle while the receiver takes the results,
//   set by the registered cell update and the one-deep output register.
//   when the receiver stalls, the result stays in the output register and a
//   new request is taken only in a cycle where that result leaves.
//   reset clears every cell, the bit count and the output valid.
//   a refused request (full or bad index) leaves the vector unchanged.
module packed_bit_vector #(
  parameter int CAPACITY = pbv_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // [7:0] index, [8] bit_value, [16:9] byte_value, [23:17] zero
  input  logic [pbv_pkg::S_TDATA_W-1:0]   s_tdata_i,
  // [2:0] op
  input  logic [pbv_pkg::S_TUSER_W-1:0]   s_tuser_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // [0] read_bit, [9:1] bit_count, [15:10] zero
  output logic [pbv_pkg::M_TDATA_W-1:0]   m_tdata_o,
  // [1:0] status
  output logic [pbv_pkg::M_TUSER_W-1:0]   m_tuser_o
);
  import pbv_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  // handshake and count
  logic            accept;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;

  // decoded request
  cell_ctrl_t      ctrl;
  status_e         status;
  logic            rd_ok;
  logic [POS_W-1:0] idx_w;
  logic [POS_W-1:0] cnt_ext;
  logic            rd_bit;

  // cell row
  logic [CAPACITY-1:0] store;

  // output register
  logic                 m_tvalid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic [M_TDATA_W-1:0] m_tdata_d;
  logic [M_TUSER_W-1:0] m_tuser_q;

  assign s_tready_o = !m_tvalid_q || m_tready_i;
  assign accept     = s_tvalid_i && s_tready_o;

  pbv_dec #(
    .CAPACITY (CAPACITY),
    .CntW     (CntW)
  ) u_dec (
    .go_i         (accept),
    .op_i         (op_e'(s_tuser_i[2:0])),
    .index_i      (s_tdata_i[7:0]),
    .bit_value_i  (s_tdata_i[8]),
    .byte_value_i (s_tdata_i[16:9]),
    .cnt_i        (cnt_q),
    .ctrl_o       (ctrl),
    .status_o     (status),
    .rd_ok_o      (rd_ok),
    .cnt_d_o      (cnt_d)
  );

  // row of cells, edges fed with zero
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic lower;
    logic lower8;
    logic upper;
    if (g > 0) begin : g_lo
      assign lower = store[g-1];
    end else begin : g_lo0
      assign lower = 1'b0;
    end
    if (g >= BYTE_BITS) begin : g_lo8
      assign lower8 = store[g-BYTE_BITS];
    end else begin : g_lo80
      assign lower8 = 1'b0;
    end
    if (g < CAPACITY - 1) begin : g_up
      assign upper = store[g+1];
    end else begin : g_up0
      assign upper = 1'b0;
    end
    pbv_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .lower_i  (lower),
      .lower8_i (lower8),
      .upper_i  (upper),
      .bit_o    (store[g])
    );
  end

  // read select over the row, one compare per cell
  always_comb begin
    idx_w  = POS_W'(s_tdata_i[7:0]);
    rd_bit = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (POS_W'(i) == idx_w) begin
        rd_bit = store[i];
      end
    end
    rd_bit = rd_bit && rd_ok;
  end

  always_comb begin
    cnt_ext   = POS_W'(cnt_d);
    m_tdata_d = M_TDATA_W'({cnt_ext[COUNT_OUT_W-1:0], rd_bit});
  end

  // bit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (accept) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_tdata_q <= m_tdata_d;
      m_tuser_q <= status;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

  // count never passes the row length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("bit count above capacity");

  // a refused request leaves the count alone
  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (status != ST_OK) |=> $stable(cnt_q))
    else $error("refused request changed the count");

  // cells never shift both ways at once
  a_one_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.write && ctrl.erase))
    else $error("insert and erase together");

  // a refused result carries no read bit
  a_refused_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_q && (m_tuser_q != ST_OK) |-> !m_tdata_q[0])
    else $error("read bit on refused request");

  // the shift happens only with a taken request
  a_shift_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.write || ctrl.erase) |-> accept)
    else $error("cells shifted without a request");

endmodule
